[rtl/core/complex_number_alu_macros.svh]
// Assertion macros for the complex number ALU.
// Expects clk and rst_n in the scope of the including module.
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CNA_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CNA_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/core/cna_pkg.sv]
// Shared types and constants for the complex number ALU.
// No dependencies.
package cna_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

[rtl/core/complex_number_alu.sv]
// Complex number ALU: add, subtract, multiply and divide on signed fixed point.
// Input channel: in_valid/in_stall with operation, a_real, a_imag, b_real, b_imag.
// Output channel: out_valid/out_stall with res_real, res_imag, overflow, div_zero.
// A request is taken on a rising edge with valid high and stall low.
// Throughput is one request per cycle while out_stall does not hold the back
// pipeline, set by the fully pipelined restoring divider (one quotient bit
// per stage, both parts side by side).
// A request first sits in the front register, then in a four-entry queue,
// then enters the back pipeline (products, combine, divide, saturate).
// When out_stall is high with out_valid set, the whole back pipeline holds;
// the queue absorbs requests until full, then in_stall rises.
// Reset clears all valid bits and queue pointers; nothing else needs reset.
// Multiply truncates toward minus infinity, divide toward zero; parts out of
// range saturate and set overflow; divide by zero magnitude gives zero and
// sets div_zero.
// Depends on cna_pkg, cna_front, cna_queue, cna_back and the macro header.
`include "complex_number_alu_macros.svh"

module complex_number_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic signed [DATA_WIDTH-1:0]  a_real,
    input  logic signed [DATA_WIDTH-1:0]  a_imag,
    input  logic signed [DATA_WIDTH-1:0]  b_real,
    input  logic signed [DATA_WIDTH-1:0]  b_imag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  res_real,
    output logic signed [DATA_WIDTH-1:0]  res_imag,
    output logic                          overflow,
    output logic                          div_zero
);
    import cna_pkg::*;

    localparam int EW = 4*DATA_WIDTH + 2;
    localparam logic signed [DATA_WIDTH-1:0] RMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] RMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    q_stat_t        q_stat;
    logic           push;
    logic           pop;
    logic [EW-1:0]  push_data;
    logic [EW-1:0]  pop_data;

    cna_front #(.DW(DATA_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    cna_queue #(.W(EW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    cna_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop       (pop),
        .q_data    (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_real  (res_real),
        .res_imag  (res_imag),
        .overflow  (overflow),
        .div_zero  (div_zero)
    );

    `CNA_ASSERT_IMP(a_dz_zero, out_valid && div_zero, res_real == '0 && res_imag == '0 && !overflow, "div_zero result not zero")
    `CNA_ASSERT_IMP(a_ovf_sat, out_valid && overflow, res_real == RMAX || res_real == RMIN || res_imag == RMAX || res_imag == RMIN, "overflow without saturated part")
    `CNA_ASSERT_NXT(a_push_fill, push, q_stat.not_empty, "queue empty after push")
    `CNA_ASSERT_IMP(a_pop_avail, pop, q_stat.not_empty, "pop from empty queue")

endmodule

[rtl/core/cna_front.sv]
// Front end of the complex number ALU: takes requests and holds each in a register until the queue takes it.
// Depends on cna_pkg.
module cna_front #(
    parameter int DW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic signed [DW-1:0]  a_real,
    input  logic signed [DW-1:0]  a_imag,
    input  logic signed [DW-1:0]  b_real,
    input  logic signed [DW-1:0]  b_imag,
    input  cna_pkg::q_stat_t      q_stat,
    output logic                  push,
    output logic [4*DW+1:0]       push_data
);
    import cna_pkg::*;

    logic            hold_valid_reg;
    logic            hold_valid_next;
    op_t             op_reg;
    logic [DW-1:0]   ar_reg;
    logic [DW-1:0]   ai_reg;
    logic [DW-1:0]   br_reg;
    logic [DW-1:0]   bi_reg;
    logic            accept;

    assign in_stall  = hold_valid_reg && q_stat.full;
    assign push      = hold_valid_reg && !q_stat.full;
    assign accept    = in_valid && !in_stall;
    assign push_data = {op_reg, ar_reg, ai_reg, br_reg, bi_reg};

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(operation);
            ar_reg <= a_real;
            ai_reg <= a_imag;
            br_reg <= b_real;
            bi_reg <= b_imag;
        end
    end

endmodule

[rtl/core/cna_queue.sv]
// Small request queue between the front and back of the complex number ALU.
// Depends on cna_pkg.
module cna_queue #(
    parameter int W = 130
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [W-1:0]      push_data,
    input  logic              pop,
    output logic [W-1:0]      pop_data,
    output cna_pkg::q_stat_t  q_stat
);
    import cna_pkg::*;

    logic [W-1:0]    mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign pop_data         = mem[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/cna_back.sv]
// Back end of the complex number ALU: multiply, combine, pipelined restoring
// divide and saturation. Depends on cna_pkg.
module cna_back #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cna_pkg::q_stat_t      q_stat,
    output logic                  pop,
    input  logic [4*DW+1:0]       q_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [DW-1:0]  res_real,
    output logic signed [DW-1:0]  res_imag,
    output logic                  overflow,
    output logic                  div_zero
);
    import cna_pkg::*;

    localparam int PW   = 2*DW;
    localparam int VW   = 2*DW + 1;
    localparam int NW   = VW + FB;
    localparam int CW   = NW + DW;
    localparam int DENW = 2*DW;
    localparam logic signed [NW-1:0] SMAX = (NW'(1) << (DW-1)) - NW'(1);
    localparam logic signed [NW-1:0] SMIN = -SMAX - NW'(1);
    localparam logic signed [NW-1:0] BIGV = NW'(1) << DW;

    logic adv;
    assign adv = !out_valid || !out_stall;
    assign pop = adv && q_stat.not_empty;

    // unpack the queue entry
    op_t                 q_op;
    logic signed [DW-1:0] q_ar, q_ai, q_br, q_bi;
    assign q_op = op_t'(q_data[4*DW+1 -: 2]);
    assign q_ar = q_data[4*DW-1 -: DW];
    assign q_ai = q_data[3*DW-1 -: DW];
    assign q_br = q_data[2*DW-1 -: DW];
    assign q_bi = q_data[DW-1 -: DW];

    // stage 1: products
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic signed [DW-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bbr_reg, p_bbi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_stat.not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= q_op;
            s1_ar_reg <= q_ar;
            s1_ai_reg <= q_ai;
            s1_br_reg <= q_br;
            s1_bi_reg <= q_bi;
            p_rr_reg  <= PW'(q_ar) * PW'(q_br);
            p_ii_reg  <= PW'(q_ai) * PW'(q_bi);
            p_ri_reg  <= PW'(q_ar) * PW'(q_bi);
            p_ir_reg  <= PW'(q_ai) * PW'(q_br);
            p_bbr_reg <= PW'(q_br) * PW'(q_br);
            p_bbi_reg <= PW'(q_bi) * PW'(q_bi);
        end
    end

    // stage 2: combine into per-lane values, or divide operands
    logic signed [VW-1:0] c_re, c_im, n_re, n_im;
    logic [VW-1:0]        mag_re, mag_im;
    logic [NW-1:0]        num_re, num_im;
    logic [DENW-1:0]      c_den;
    logic                 c_div;
    logic [NW-1:0]        c_rem_re, c_rem_im;
    logic                 c_big_re, c_big_im;

    always_comb
    begin
        c_div = (s1_op_reg == OP_DIV);
        n_re  = VW'(p_rr_reg) + VW'(p_ii_reg);
        n_im  = VW'(p_ir_reg) - VW'(p_ri_reg);
        c_den = DENW'($unsigned(p_bbr_reg)) + DENW'($unsigned(p_bbi_reg));
        mag_re = n_re[VW-1] ? $unsigned(-n_re) : $unsigned(n_re);
        mag_im = n_im[VW-1] ? $unsigned(-n_im) : $unsigned(n_im);
        num_re = {mag_re, {FB{1'b0}}};
        num_im = {mag_im, {FB{1'b0}}};
        c_big_re = CW'(num_re) >= (CW'(c_den) << DW);
        c_big_im = CW'(num_im) >= (CW'(c_den) << DW);
        case (s1_op_reg)
            OP_ADD:
            begin
                c_re = VW'(s1_ar_reg) + VW'(s1_br_reg);
                c_im = VW'(s1_ai_reg) + VW'(s1_bi_reg);
            end
            OP_SUB:
            begin
                c_re = VW'(s1_ar_reg) - VW'(s1_br_reg);
                c_im = VW'(s1_ai_reg) - VW'(s1_bi_reg);
            end
            OP_MUL:
            begin
                c_re = (VW'(p_rr_reg) - VW'(p_ii_reg)) >>> FB;
                c_im = (VW'(p_ri_reg) + VW'(p_ir_reg)) >>> FB;
            end
            default:
            begin
                c_re = n_re;
                c_im = n_im;
            end
        endcase
        c_rem_re = c_div ? num_re : NW'(c_re);
        c_rem_im = c_div ? num_im : NW'(c_im);
    end

    // divide stages: stage k+1 resolves quotient bit DW-1-k
    logic            st_valid_reg [DW+1];
    logic            st_div_reg   [DW+1];
    logic            st_dz_reg    [DW+1];
    logic [DENW-1:0] st_den_reg   [DW+1];
    logic [NW-1:0]   st_rre_reg   [DW+1];
    logic [NW-1:0]   st_rim_reg   [DW+1];
    logic [DW-1:0]   st_qre_reg   [DW+1];
    logic [DW-1:0]   st_qim_reg   [DW+1];
    logic            st_nre_reg   [DW+1];
    logic            st_nim_reg   [DW+1];
    logic            st_bre_reg   [DW+1];
    logic            st_bim_reg   [DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_div_reg[0] <= c_div;
            st_dz_reg[0]  <= (c_den == '0);
            st_den_reg[0] <= c_den;
            st_rre_reg[0] <= c_rem_re;
            st_rim_reg[0] <= c_rem_im;
            st_qre_reg[0] <= '0;
            st_qim_reg[0] <= '0;
            st_nre_reg[0] <= n_re[VW-1];
            st_nim_reg[0] <= n_im[VW-1];
            st_bre_reg[0] <= c_big_re;
            st_bim_reg[0] <= c_big_im;
        end
    end

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        localparam int BIT = DW - 1 - k;
        logic [CW-1:0] d_sh;
        logic          ge_re, ge_im;

        assign d_sh  = CW'(st_den_reg[k]) << BIT;
        assign ge_re = st_div_reg[k] && (CW'(st_rre_reg[k]) >= d_sh);
        assign ge_im = st_div_reg[k] && (CW'(st_rim_reg[k]) >= d_sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                st_valid_reg[k+1] <= st_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_div_reg[k+1] <= st_div_reg[k];
                st_dz_reg[k+1]  <= st_dz_reg[k];
                st_den_reg[k+1] <= st_den_reg[k];
                st_rre_reg[k+1] <= ge_re ? st_rre_reg[k] - d_sh[NW-1:0] : st_rre_reg[k];
                st_rim_reg[k+1] <= ge_im ? st_rim_reg[k] - d_sh[NW-1:0] : st_rim_reg[k];
                st_qre_reg[k+1] <= st_qre_reg[k] | (DW'(ge_re) << BIT);
                st_qim_reg[k+1] <= st_qim_reg[k] | (DW'(ge_im) << BIT);
                st_nre_reg[k+1] <= st_nre_reg[k];
                st_nim_reg[k+1] <= st_nim_reg[k];
                st_bre_reg[k+1] <= st_bre_reg[k];
                st_bim_reg[k+1] <= st_bim_reg[k];
            end
        end
    end

    // final: sign, saturate, register the result
    function automatic logic [DW:0] saturate(input logic signed [NW-1:0] v);
        logic [DW:0] r;
        if (v > SMAX)
        begin
            r = {1'b1, SMAX[DW-1:0]};
        end
        else if (v < SMIN)
        begin
            r = {1'b1, SMIN[DW-1:0]};
        end
        else
        begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    logic signed [NW-1:0] f_re, f_im, qv_re, qv_im;
    logic [DW:0]          sat_re, sat_im;

    always_comb
    begin
        qv_re = NW'({1'b0, st_qre_reg[DW]});
        qv_im = NW'({1'b0, st_qim_reg[DW]});
        if (st_bre_reg[DW]) qv_re = BIGV;
        if (st_bim_reg[DW]) qv_im = BIGV;
        if (st_nre_reg[DW]) qv_re = -qv_re;
        if (st_nim_reg[DW]) qv_im = -qv_im;
        f_re   = st_div_reg[DW] ? qv_re : $signed(st_rre_reg[DW]);
        f_im   = st_div_reg[DW] ? qv_im : $signed(st_rim_reg[DW]);
        sat_re = saturate(f_re);
        sat_im = saturate(f_im);
        if (st_div_reg[DW] && st_dz_reg[DW])
        begin
            sat_re = '0;
            sat_im = '0;
        end
    end

    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= st_valid_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_real <= sat_re[DW-1:0];
            res_imag <= sat_im[DW-1:0];
            overflow <= sat_re[DW] | sat_im[DW];
            div_zero <= st_div_reg[DW] && st_dz_reg[DW];
        end
    end

endmodule

[bench/complex_number_alu_test.sv]
// Self-checking bench for complex_number_alu: directed table, then random requests
// with random gaps and stalls on both channels. Depends on cna_pkg and the RTL.
module complex_number_alu_test;
    import cna_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 4;
    localparam int N_RANDOM = 1930;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [DW-1:0] MINV = 32'sh80000000;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic ovf;
        logic dz;
    } cplx_res_t;

    typedef struct {
        op_t op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
        bit known;
        cplx_res_t res;
    } stim_row_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] operation;
    logic signed [DW-1:0] a_real, a_imag, b_real, b_imag;
    logic signed [DW-1:0] res_real, res_imag;
    logic overflow, div_zero;

    cplx_res_t pending_results[$];
    int errors = 0;
    int n_results = 0;
    int n_requests = 0;
    int op_count[4] = '{0, 0, 0, 0};
    longint cycles = 0;
    bit hold_long = 0;
    bit feeding_done = 0;

    complex_number_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .a_real(a_real), .a_imag(a_imag),
        .b_real(b_real), .b_imag(b_imag),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_real(res_real), .res_imag(res_imag),
        .overflow(overflow), .div_zero(div_zero)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [DW-1:0] clamp(logic signed [127:0] v, inout logic ovf);
        if (v > 128'(MAXV))
        begin
            ovf = 1;
            return MAXV;
        end
        if (v < 128'(MINV))
        begin
            ovf = 1;
            return MINV;
        end
        return v[DW-1:0];
    endfunction

    // Signed division truncating toward zero; divisor is positive.
    function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic [127:0] q;
        q = (n < 0) ? (-n) / d : n / d;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic cplx_res_t complex_op(op_t op, logic signed [DW-1:0] ar,
                                             logic signed [DW-1:0] ai,
                                             logic signed [DW-1:0] br,
                                             logic signed [DW-1:0] bi);
        cplx_res_t r;
        logic signed [127:0] xr, xi, yr, yi, re, im, den;
        xr = ar; xi = ai; yr = br; yi = bi;
        r.ovf = 0;
        r.dz = 0;
        case (op)
            OP_ADD: begin re = xr + yr; im = xi + yi; end
            OP_SUB: begin re = xr - yr; im = xi - yi; end
            OP_MUL:
            begin
                re = (xr * yr - xi * yi) >>> FB;
                im = (xr * yi + xi * yr) >>> FB;
            end
            default:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                begin
                    r.dz = 1;
                    re = 0;
                    im = 0;
                end
                else
                begin
                    re = div_trunc((xr * yr + xi * yi) <<< FB, den);
                    im = div_trunc((xi * yr - xr * yi) <<< FB, den);
                end
            end
        endcase
        r.re = clamp(re, r.ovf);
        r.im = clamp(im, r.ovf);
        return r;
    endfunction

    task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
    endtask

    function automatic logic signed [DW-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return MAXV;
            1: return MINV;
            2: return 0;
            3: return $signed(DW'($urandom_range(0, 6) << FB)) * ($urandom_range(0, 1) ? 1 : -1);
            4: return DW'($signed($urandom_range(0, 2047)) - 1024);
            5: return $signed({{16{1'b0}}, 16'($urandom)}) - 32'sh8000 + 32'($urandom_range(0, 3) << 16);
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until accepted.
    task automatic send(op_t op, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                        logic signed [DW-1:0] br, logic signed [DW-1:0] bi,
                        bit known, cplx_res_t want);
        cplx_res_t p;
        p = complex_op(op, ar, ai, br, bi);
        if (known && (p.re !== want.re || p.im !== want.im ||
                      p.ovf !== want.ovf || p.dz !== want.dz))
        begin
            errors++;
            $display("table row disagrees with predictor for op %s", op.name());
        end
        in_valid <= 1;
        operation <= op;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(p);
        op_count[op]++;
        n_requests++;
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    stim_row_t table_rows[$];

    function automatic stim_row_t row(op_t op, int ar, int ai, int br, int bi,
                                      bit known, int re, int im, bit ovf, bit dz);
        stim_row_t s;
        s.op = op; s.ar = ar; s.ai = ai; s.br = br; s.bi = bi;
        s.known = known;
        s.res.re = re; s.res.im = im; s.res.ovf = ovf; s.res.dz = dz;
        return s;
    endfunction

    initial
    begin
        cplx_res_t none;
        op_t op;
        none = '{default: 0};
        rst_n = 0;
        in_valid = 0;
        operation = OP_ADD;
        a_real = 0; a_imag = 0; b_real = 0; b_imag = 0;
        table_rows = '{
            row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0),
            row(OP_ADD, 32'h7fffffff, 32'h80000000, 1, -1, 1, 32'h7fffffff, 32'h80000000, 1, 0),
            row(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1, -1, -1, 0, 0),
            row(OP_SUB, 32'h80000000, 32'h7fffffff, 1, -1, 1, 32'h80000000, 32'h7fffffff, 1, 0),
            row(OP_SUB, 32'h80000000, 0, 32'h80000000, 0, 1, 0, 0, 0, 0),
            row(OP_SUB, 5, 7, 2, 3, 1, 3, 4, 0, 0),
            row(OP_MUL, 32'h10000, 32'h20000, 32'h30000, 32'h40000, 1,
                32'hfffb0000, 32'h000a0000, 0, 0),
            row(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
                0, 32'h7fffffff, 1, 0),
            row(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0),
            row(OP_MUL, -1, 0, 1, 0, 1, -1, 0, 0, 0),
            row(OP_MUL, 0, 0, 32'h80000000, 32'h7fffffff, 1, 0, 0, 0, 0),
            row(OP_DIV, 32'h10000, 0, 0, 0, 1, 0, 0, 0, 1),
            row(OP_DIV, 32'h7fffffff, 32'h80000000, 0, 0, 1, 0, 0, 0, 1),
            row(OP_DIV, 32'h10000, 32'h10000, 32'h10000, 0, 1, 32'h10000, 32'h10000, 0, 0),
            row(OP_DIV, 32'h7fffffff, 0, 1, 0, 1, 32'h7fffffff, 0, 1, 0),
            row(OP_DIV, 32'h80000000, 0, 1, 0, 1, 32'h80000000, 0, 1, 0),
            row(OP_DIV, -1, 0, 32'h30000, 0, 0, 0, 0, 0, 0),
            row(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0),
            row(OP_DIV, 1, 1, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0),
            row(OP_DIV, 32'h12345, 32'h6789a, 32'h80000000, 1, 0, 0, 0, 0, 0)
        };
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (table_rows[i])
        begin
            send(table_rows[i].op, table_rows[i].ar, table_rows[i].ai,
                 table_rows[i].br, table_rows[i].bi, table_rows[i].known,
                 table_rows[i].res);
            idle_gap();
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            op = op_t'($urandom_range(0, 3));
            // Long receiver hold-off while the sender keeps offering requests.
            if (n == 300)
                hold_long = 1;
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
                send(op, rand_value(), rand_value(), 0, 0, 0, none);
            else
                send(op, rand_value(), rand_value(), rand_value(), rand_value(), 0, none);
            if (!hold_long)
                idle_gap();
        end
        in_valid <= 0;
        feeding_done = 1;
    end

    // Receiver stall: random gaps, one long forced hold-off.
    initial
    begin
        int g;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1;
                repeat (200) @(posedge clk);
                hold_long = 0;
            end
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 2);
            if (g > 0)
            begin
                out_stall <= 1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cplx_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("result %0d arrived with no request pending", n_results);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_real !== want.re) report("res_real", res_real, want.re);
                if (res_imag !== want.im) report("res_imag", res_imag, want.im);
                if (overflow !== want.ovf) report("overflow", overflow, want.ovf);
                if (div_zero !== want.dz) report("div_zero", div_zero, want.dz);
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (feeding_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d requests: %0d add, %0d sub, %0d mul, %0d div; %0d results checked",
                 n_requests, op_count[0], op_count[1], op_count[2], op_count[3], n_results);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
